### design/lsc_pkg.sv
// Shared types and constants for the line segment classifier.
// No dependencies; every other file of the block imports it.
package lsc_pkg;

  // Configuration register widths
  localparam int SKY_W = 10;
  localparam int FH_W  = 11;
  localparam int CFG_W = 11;

  // Register indexes on the configuration port
  typedef enum logic [0:0] {
    REG_SKY_ROW      = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // Result classes
  typedef enum logic [1:0] {
    CLASS_DROP = 2'd0,
    CLASS_STOP = 2'd1,
    CLASS_LANE = 2'd2
  } seg_class_t;

  // tan(15 deg) in Q0.32
  localparam logic [31:0] TAN15_Q32 = 32'd1150833018;

  // floor(n/3) = (n * 2731) >> 13, exact for n < 8192
  localparam int          DIV3_MULT_W = 12;
  localparam logic [11:0] DIV3_MULT   = 12'd2731;
  localparam int          DIV3_SHIFT  = 13;

  // floor(n/10) = (n * 52429) >> 19, exact for n < 262144
  localparam int          DIV10_MULT_W = 16;
  localparam logic [15:0] DIV10_MULT   = 16'd52429;
  localparam int          DIV10_SHIFT  = 19;

  // Weight output
  localparam int         WEIGHT_W   = 8;
  localparam logic [7:0] WEIGHT_MAX = 8'd255;
  localparam logic [7:0] WEIGHT_MIN = 8'd1;

  // Reset values: sky row 0, frame height 240 -> cut row 160
  localparam logic [SKY_W-1:0] SKY_RESET = 10'd0;
  localparam logic [FH_W-1:0]  CUT_RESET = 11'd160;

endpackage

### design/line_segment_classifier.sv
// Line segment classifier: top level with configuration registers.
// Instantiates lsc_geom, lsc_isqrt and lsc_weight; depends on lsc_pkg.
//
// Usage: one segment (start_x/y, end_x/y) is taken per beat on the input
// channel (in_valid/in_ready) and one result (segment_class, segment_weight,
// lower_x/y, upper_x/y) leaves per beat on the output channel
// (out_valid/out_ready). Class 0 is dropped (weight 0, endpoints as given),
// 1 a stop line (endpoints as given), 2 a lane line (lower end first).
// A segment passes through three geometry stages, the square root
// pipeline resolving four root bits per stage, and the weight/output
// register. Throughput is one segment per cycle while out_ready stays
// high, since every stage is a plain pipeline register.
// Configuration: cfg_write with cfg_index 0 sets the sky row, 1 sets
// frame_height; the cut row floor(frame_height/3)*2 is computed on the write.
// Reset clears all valid bits and loads sky row 0, frame_height 240.
// When the receiver stalls, results stay in place and empty stages keep
// filling; in_ready drops only once every stage holds a segment.
module line_segment_classifier import lsc_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            segment_class,
  output logic [WEIGHT_W-1:0]   segment_weight,
  output logic [COORD_BITS-1:0] lower_x,
  output logic [COORD_BITS-1:0] lower_y,
  output logic [COORD_BITS-1:0] upper_x,
  output logic [COORD_BITS-1:0] upper_y
);

  localparam int C         = COORD_BITS;
  localparam int LEN_SQ_W  = 2 * C + 1;
  localparam int ROOT_W    = (LEN_SQ_W + 1) / 2;
  localparam int SIDE_W    = 2 + 4 * C;
  localparam int FH_PROD_W = FH_W + DIV3_MULT_W;

  // Configuration registers
  logic [SKY_W-1:0]     sky_row;
  logic [FH_W-1:0]      cut_row;
  logic [FH_PROD_W-1:0] fh_prod;
  logic [FH_W-1:0]      fh_third;
  logic [FH_W-1:0]      cut_next;

  // floor(frame_height / 3) * 2 by reciprocal multiply
  always_comb begin
    fh_prod  = FH_PROD_W'(cfg_data) * FH_PROD_W'(DIV3_MULT);
    fh_third = FH_W'(fh_prod >> DIV3_SHIFT);
    cut_next = {fh_third[FH_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sky_row <= SKY_RESET;
      cut_row <= CUT_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SKY_ROW:      sky_row <= cfg_data[SKY_W-1:0];
        REG_FRAME_HEIGHT: cut_row <= cut_next;
        default:          ;
      endcase
    end
  end

  // Geometry stages
  logic          g_valid, g_ready;
  logic [LEN_SQ_W-1:0] g_len_sq;
  seg_class_t    g_class;
  logic [C-1:0]  g_fx, g_fy, g_sx, g_sy;

  lsc_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk       (clk),
    .rst       (rst),
    .sky_row   (sky_row),
    .cut_row   (cut_row),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .len_sq    (g_len_sq),
    .seg_class (g_class),
    .first_x   (g_fx),
    .first_y   (g_fy),
    .second_x  (g_sx),
    .second_y  (g_sy)
  );

  // Square root pipeline, class and endpoints ride along
  logic              r_valid, r_ready;
  logic [ROOT_W-1:0] r_root;
  logic [SIDE_W-1:0] r_side;
  logic [SIDE_W-1:0] g_side;

  assign g_side = {g_class, g_fx, g_fy, g_sx, g_sy};

  lsc_isqrt #(
    .IN_W            (LEN_SQ_W),
    .SIDE_W          (SIDE_W),
    .STEPS_PER_STAGE (4)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .radicand  (g_len_sq),
    .in_side   (g_side),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .root      (r_root),
    .out_side  (r_side)
  );

  // Weight and output register
  seg_class_t w_class;

  lsc_weight #(
    .ROOT_W     (ROOT_W),
    .COORD_BITS (COORD_BITS)
  ) u_weight (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (r_valid),
    .in_ready       (r_ready),
    .root           (r_root),
    .in_class       (seg_class_t'(r_side[SIDE_W-1 -: 2])),
    .in_first_x     (r_side[4*C-1 -: C]),
    .in_first_y     (r_side[3*C-1 -: C]),
    .in_second_x    (r_side[2*C-1 -: C]),
    .in_second_y    (r_side[C-1:0]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .segment_class  (w_class),
    .segment_weight (segment_weight),
    .lower_x        (lower_x),
    .lower_y        (lower_y),
    .upper_x        (upper_x),
    .upper_y        (upper_y)
  );

  assign segment_class = w_class;

endmodule

### design/lsc_geom.sv
// Geometry pipeline: sky/floor drop test, endpoint distances, squared length,
// 15 degree angle test and lane endpoint ordering. Three register stages.
// Depends on lsc_pkg.
module lsc_geom import lsc_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [SKY_W-1:0]        sky_row,
  input  logic [FH_W-1:0]         cut_row,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_BITS-1:0]   start_x,
  input  logic [COORD_BITS-1:0]   start_y,
  input  logic [COORD_BITS-1:0]   end_x,
  input  logic [COORD_BITS-1:0]   end_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2*COORD_BITS:0]   len_sq,
  output seg_class_t              seg_class,
  output logic [COORD_BITS-1:0]   first_x,
  output logic [COORD_BITS-1:0]   first_y,
  output logic [COORD_BITS-1:0]   second_x,
  output logic [COORD_BITS-1:0]   second_y
);

  localparam int C     = COORD_BITS;
  localparam int CMP_W = (C > FH_W) ? C : FH_W;
  localparam int TAN_W = C + 32;
  localparam int SQ_W  = 2 * C;

  // Stage 1: drop test and absolute distances
  logic         v1;
  logic [C-1:0] s1_sx, s1_sy, s1_ex, s1_ey, s1_dx, s1_dy;
  logic         s1_drop;

  // Stage 2: products
  logic             v2;
  logic [C-1:0]     s2_sx, s2_sy, s2_ex, s2_ey, s2_dy;
  logic             s2_drop, s2_zero;
  logic [SQ_W-1:0]  s2_dx2, s2_dy2;
  logic [TAN_W-1:0] s2_tan;

  // Stage 3: length sum, class, ordered endpoints
  logic v3;

  logic rdy1, rdy2, rdy3;
  logic drop_in;
  logic [C-1:0] dx_in, dy_in;
  logic stop_c;
  seg_class_t class_c;
  logic swap_c;

  // Bubble-collapsing handshake along the three stages
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;

  // Drop when one end is above the sky row and the other above the cut
  always_comb begin
    drop_in = ((CMP_W'(start_y) < CMP_W'(sky_row)) && (CMP_W'(end_y) < CMP_W'(cut_row)))
           || ((CMP_W'(end_y) < CMP_W'(sky_row)) && (CMP_W'(start_y) < CMP_W'(cut_row)));
    dx_in = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
    dy_in = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
  end

  // Angle test |dy| * 2^32 < tan15 * |dx|; zero length counts as stop
  always_comb begin
    stop_c = s2_zero || ({s2_dy, 32'd0} < s2_tan);
    if (s2_drop) begin
      class_c = CLASS_DROP;
    end else if (stop_c) begin
      class_c = CLASS_STOP;
    end else begin
      class_c = CLASS_LANE;
    end
    swap_c = (class_c == CLASS_LANE) && (s2_sy < s2_ey);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_sx   <= start_x;
      s1_sy   <= start_y;
      s1_ex   <= end_x;
      s1_ey   <= end_y;
      s1_dx   <= dx_in;
      s1_dy   <= dy_in;
      s1_drop <= drop_in;
    end
    if (rdy2 && v1) begin
      s2_sx   <= s1_sx;
      s2_sy   <= s1_sy;
      s2_ex   <= s1_ex;
      s2_ey   <= s1_ey;
      s2_dy   <= s1_dy;
      s2_drop <= s1_drop;
      s2_zero <= (s1_dx == '0) && (s1_dy == '0);
      s2_dx2  <= SQ_W'(s1_dx) * SQ_W'(s1_dx);
      s2_dy2  <= SQ_W'(s1_dy) * SQ_W'(s1_dy);
      s2_tan  <= TAN_W'(s1_dx) * TAN_W'(TAN15_Q32);
    end
    if (rdy3 && v2) begin
      len_sq    <= (SQ_W + 1)'(s2_dx2) + (SQ_W + 1)'(s2_dy2);
      seg_class <= class_c;
      first_x   <= swap_c ? s2_ex : s2_sx;
      first_y   <= swap_c ? s2_ey : s2_sy;
      second_x  <= swap_c ? s2_sx : s2_ex;
      second_y  <= swap_c ? s2_sy : s2_ey;
    end
  end

endmodule

### design/lsc_isqrt.sv
// Pipelined integer square root (floor), a few root bits per stage, with a
// sideband word carried alongside. Depends on lsc_pkg only by convention.
module lsc_isqrt import lsc_pkg::*; #(
  parameter int IN_W            = 21,
  parameter int SIDE_W          = 42,
  parameter int STEPS_PER_STAGE = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [IN_W-1:0]          radicand,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [(IN_W+1)/2-1:0]    root,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int RW    = (IN_W + 1) / 2;
  localparam int NW    = 2 * RW;
  localparam int REM_W = RW + 3;
  localparam int NS    = (RW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // Index 0 is the input side, index s+1 the register of stage s
  logic              st_valid [NS+1];
  logic [NW-1:0]     st_num   [NS+1];
  logic [REM_W-1:0]  st_rem   [NS+1];
  logic [RW-1:0]     st_root  [NS+1];
  logic [SIDE_W-1:0] st_side  [NS+1];
  logic              st_rdy   [NS];

  assign st_valid[0] = in_valid;
  assign st_num[0]   = NW'(radicand);
  assign st_rem[0]   = '0;
  assign st_root[0]  = '0;
  assign st_side[0]  = in_side;
  assign in_ready    = st_rdy[0];

  assign out_valid = st_valid[NS];
  assign root      = st_root[NS];
  assign out_side  = st_side[NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [NW-1:0]    num_c;
    logic [REM_W-1:0] rem_c;
    logic [RW-1:0]    root_c;

    // Handshake: a stage loads when empty or when the next one moves
    if (s == NS - 1) begin : g_last
      assign st_rdy[s] = !st_valid[s+1] || out_ready;
    end else begin : g_mid
      assign st_rdy[s] = !st_valid[s+1] || st_rdy[s+1];
    end

    // Restoring digit recurrence, two radicand bits per root bit
    always_comb begin
      logic [REM_W-1:0] trial;
      logic [REM_W-1:0] rem_sh;
      trial  = '0;
      rem_sh = '0;
      num_c  = st_num[s];
      rem_c  = st_rem[s];
      root_c = st_root[s];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        if (s * STEPS_PER_STAGE + j < RW) begin
          rem_sh = {rem_c[REM_W-3:0], num_c[NW-1 -: 2]};
          trial  = {REM_W'(root_c) << 2} | REM_W'(1);
          num_c  = num_c << 2;
          if (rem_sh >= trial) begin
            rem_c  = rem_sh - trial;
            root_c = {root_c[RW-2:0], 1'b1};
          end else begin
            rem_c  = rem_sh;
            root_c = {root_c[RW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s+1] <= 1'b0;
      end else if (st_rdy[s]) begin
        st_valid[s+1] <= st_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (st_rdy[s] && st_valid[s]) begin
        st_num[s+1]  <= num_c;
        st_rem[s+1]  <= rem_c;
        st_root[s+1] <= root_c;
        st_side[s+1] <= st_side[s];
      end
    end
  end

endmodule

### design/lsc_weight.sv
// Weight stage and output register: length div 10, clamped to 1..255,
// zero for dropped segments. Depends on lsc_pkg.
module lsc_weight import lsc_pkg::*; #(
  parameter int ROOT_W     = 11,
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ROOT_W-1:0]     root,
  input  seg_class_t            in_class,
  input  logic [COORD_BITS-1:0] in_first_x,
  input  logic [COORD_BITS-1:0] in_first_y,
  input  logic [COORD_BITS-1:0] in_second_x,
  input  logic [COORD_BITS-1:0] in_second_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output seg_class_t            segment_class,
  output logic [WEIGHT_W-1:0]   segment_weight,
  output logic [COORD_BITS-1:0] lower_x,
  output logic [COORD_BITS-1:0] lower_y,
  output logic [COORD_BITS-1:0] upper_x,
  output logic [COORD_BITS-1:0] upper_y
);

  localparam int PROD_W = ROOT_W + DIV10_MULT_W;

  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   quot;
  logic [WEIGHT_W-1:0] weight_c;

  assign in_ready = !out_valid || out_ready;

  // Divide by 10 through the reciprocal, then clamp
  always_comb begin
    prod = PROD_W'(root) * PROD_W'(DIV10_MULT);
    quot = prod >> DIV10_SHIFT;
    if (in_class == CLASS_DROP) begin
      weight_c = '0;
    end else if (quot > PROD_W'(WEIGHT_MAX)) begin
      weight_c = WEIGHT_MAX;
    end else if (quot == '0) begin
      weight_c = WEIGHT_MIN;
    end else begin
      weight_c = quot[WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      segment_class  <= in_class;
      segment_weight <= weight_c;
      lower_x        <= in_first_x;
      lower_y        <= in_first_y;
      upper_x        <= in_second_x;
      upper_y        <= in_second_y;
    end
  end

endmodule

### test/line_segment_classifier_test.sv
// Self-checking testbench for line_segment_classifier: a directed table followed by
// random segments under several sky row / frame height setups, checked beat by beat.
// Depends on lsc_pkg and the line_segment_classifier RTL.
module line_segment_classifier_test;
  import lsc_pkg::*;

  localparam int COORD_W      = 10;
  localparam int PIPE_LATENCY = 7;
  localparam int HOLD_CYCLES  = 60;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 94;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct {
    seg_class_t            cls;
    logic [WEIGHT_W-1:0]   weight;
    coord_t                lx, ly, ux, uy;
  } seg_result_t;

  typedef struct {
    logic [SKY_W-1:0] sky;
    logic [FH_W-1:0]  height;
    coord_t           sx, sy, ex, ey;
    bit               known;
    seg_result_t      res;
  } seg_case_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [0:0]          cfg_index = REG_SKY_ROW;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  coord_t              start_x = '0;
  coord_t              start_y = '0;
  coord_t              end_x = '0;
  coord_t              end_y = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          segment_class;
  logic [WEIGHT_W-1:0] segment_weight;
  coord_t              lower_x, lower_y, upper_x, upper_y;

  // Register copies as the block holds them (reset values)
  logic [SKY_W-1:0] sky_cfg = SKY_RESET;
  logic [FH_W-1:0]  height_cfg = 11'd240;

  seg_result_t pending_results[$];
  seg_case_t   directed_cases[$];
  int          mismatch_count = 0;
  bit          idle_on = 1'b1;
  bit          hold_start = 1'b0;
  int          hold_left = 0;

  line_segment_classifier #(.COORD_BITS(COORD_W)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .segment_class(segment_class), .segment_weight(segment_weight),
    .lower_x(lower_x), .lower_y(lower_y), .upper_x(upper_x), .upper_y(upper_y)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Expected result of one segment under the current sky row and frame height
  function automatic seg_result_t classify_segment(input coord_t sx, sy, ex, ey);
    seg_result_t     r;
    longint unsigned dx, dy, len_sq, root, wt, trial;
    int unsigned     cut;
    cut = (height_cfg / 3) * 2;
    dx = 64'((sx > ex) ? sx - ex : ex - sx);
    dy = 64'((sy > ey) ? sy - ey : ey - sy);
    r.lx = sx;
    r.ly = sy;
    r.ux = ex;
    r.uy = ey;
    // one end in the sky while the other is in the upper two thirds
    if ((sy < sky_cfg && ey < cut) || (ey < sky_cfg && sy < cut)) begin
      r.cls = CLASS_DROP;
      r.weight = '0;
      return r;
    end
    // floor square root of the squared length, one root bit at a time
    len_sq = dx * dx + dy * dy;
    root = 0;
    for (int b = 11; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= len_sq) root = trial;
    end
    wt = root / 10;
    if (wt < 64'(WEIGHT_MIN)) wt = 64'(WEIGHT_MIN);
    else if (wt > 64'(WEIGHT_MAX)) wt = 64'(WEIGHT_MAX);
    r.weight = wt[WEIGHT_W-1:0];
    // under 15 degrees: |dy| < tan15 * |dx|, compared in Q0.32
    if ((dx == 0 && dy == 0) || ((dy << 32) < TAN15_Q32 * dx)) begin
      r.cls = CLASS_STOP;
    end else begin
      r.cls = CLASS_LANE;
      if (sy < ey) begin
        r.lx = ex;
        r.ly = ey;
        r.ux = sx;
        r.uy = sy;
      end
    end
    return r;
  endfunction

  // Table rows: checked by the predictor
  function automatic void add_predicted(input logic [SKY_W-1:0] sky,
                                        input logic [FH_W-1:0] height,
                                        input coord_t sx, sy, ex, ey);
    seg_case_t c;
    c.sky = sky;
    c.height = height;
    c.sx = sx;
    c.sy = sy;
    c.ex = ex;
    c.ey = ey;
    c.known = 1'b0;
    directed_cases.insert(directed_cases.size(), c);
  endfunction

  // Table rows: result typed in
  function automatic void add_known(input logic [SKY_W-1:0] sky,
                                    input logic [FH_W-1:0] height,
                                    input coord_t sx, sy, ex, ey,
                                    input seg_class_t cls,
                                    input logic [WEIGHT_W-1:0] wt,
                                    input coord_t lx, ly, ux, uy);
    seg_case_t c;
    c.sky = sky;
    c.height = height;
    c.sx = sx;
    c.sy = sy;
    c.ex = ex;
    c.ey = ey;
    c.known = 1'b1;
    c.res.cls = cls;
    c.res.weight = wt;
    c.res.lx = lx;
    c.res.ly = ly;
    c.res.ux = ux;
    c.res.uy = uy;
    directed_cases.insert(directed_cases.size(), c);
  endfunction

  // One input beat, with a random gap in front of it
  task automatic offer_segment(input coord_t sx, sy, ex, ey, input seg_result_t want);
    if (idle_on && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 8);
    end
    in_valid <= 1'b1;
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), want);
  endtask

  // Stop offering until every result is back and the pipe is empty
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Write both registers; only called with the block idle
  task automatic load_frame_setup(input logic [SKY_W-1:0] sky, input logic [FH_W-1:0] height);
    cfg_write <= 1'b1;
    cfg_index <= REG_SKY_ROW;
    cfg_data <= CFG_W'(sky);
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= height;
    @(posedge clk);
    cfg_write <= 1'b0;
    sky_cfg = sky;
    height_cfg = height;
  endtask

  // Result side: check each beat, then pick ready for the next cycle
  initial begin
    seg_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: class %0d weight %0d (%0d,%0d)-(%0d,%0d)",
                     segment_class, segment_weight, lower_x, lower_y, upper_x, upper_y);
        end else begin
          want = pending_results.pop_front();
          if (segment_class !== want.cls || segment_weight !== want.weight ||
              lower_x !== want.lx || lower_y !== want.ly ||
              upper_x !== want.ux || upper_y !== want.uy) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch: want class %0d weight %0d (%0d,%0d)-(%0d,%0d), ",
                        "got %0d %0d (%0d,%0d)-(%0d,%0d)"},
                       want.cls, want.weight, want.lx, want.ly, want.ux, want.uy,
                       segment_class, segment_weight, lower_x, lower_y, upper_x, upper_y);
          end
        end
      end
      if (hold_start) begin
        hold_left = HOLD_CYCLES;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < 8);
      end
    end
  end

  // Stimulus
  initial begin
    seg_case_t        c;
    seg_result_t      want;
    coord_t           sx, sy, ex, ey;
    logic [SKY_W-1:0] phase_sky[PHASES];
    logic [FH_W-1:0]  phase_height[PHASES];
    int unsigned      kind, dx, dy, x0, y0, cut;
    int               v;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset setup: sky 0, cut row 160, so nothing is dropped
    add_known(0, 240, 0, 0, 0, 0, CLASS_STOP, 1, 0, 0, 0, 0);
    add_known(0, 240, 0, 0, 1023, 0, CLASS_STOP, 102, 0, 0, 1023, 0);
    add_known(0, 240, 1023, 1023, 0, 1023, CLASS_STOP, 102, 1023, 1023, 0, 1023);
    add_known(0, 240, 5, 0, 5, 1023, CLASS_LANE, 102, 5, 1023, 5, 0);
    add_known(0, 240, 5, 1023, 5, 0, CLASS_LANE, 102, 5, 1023, 5, 0);
    add_known(0, 240, 0, 0, 1023, 1023, CLASS_LANE, 144, 1023, 1023, 0, 0);
    add_known(0, 240, 1023, 0, 0, 1023, CLASS_LANE, 144, 0, 1023, 1023, 0);
    add_known(0, 240, 0, 0, 9, 0, CLASS_STOP, 1, 0, 0, 9, 0);
    add_known(0, 240, 0, 0, 20, 0, CLASS_STOP, 2, 0, 0, 20, 0);
    add_predicted(0, 240, 10, 10, 13, 14);
    // either side of 15 degrees, then a 45 degree diagonal
    add_predicted(0, 240, 0, 0, 1000, 267);
    add_predicted(0, 240, 0, 0, 1000, 268);
    add_predicted(0, 240, 0, 0, 56, 15);
    add_predicted(0, 240, 41, 0, 0, 11);
    add_predicted(0, 240, 682, 341, 0, 1023);
    // sky row 100, cut row 160
    add_known(100, 240, 0, 50, 500, 150, CLASS_DROP, 0, 0, 50, 500, 150);
    add_known(100, 240, 0, 150, 500, 50, CLASS_DROP, 0, 0, 150, 500, 50);
    add_predicted(100, 240, 0, 50, 500, 160);
    add_predicted(100, 240, 0, 99, 700, 159);
    add_predicted(100, 240, 0, 100, 700, 10);
    // register extremes; a zero frame height leaves no row above the cut
    add_known(1023, 1024, 0, 0, 0, 0, CLASS_DROP, 0, 0, 0, 0, 0);
    add_predicted(1023, 1024, 1023, 1023, 1023, 1022);
    add_known(1023, 0, 0, 0, 0, 0, CLASS_STOP, 1, 0, 0, 0, 0);
    add_predicted(1023, 2047, 1023, 1023, 0, 1022);
    add_predicted(0, 1, 512, 512, 0, 0);

    foreach (directed_cases[i]) begin
      c = directed_cases[i];
      if (c.sky != sky_cfg || c.height != height_cfg) begin
        wait_for_results();
        load_frame_setup(c.sky, c.height);
      end
      if (c.known) want = c.res;
      else want = classify_segment(c.sx, c.sy, c.ex, c.ey);
      offer_segment(c.sx, c.sy, c.ex, c.ey, want);
    end

    // random phases, one register setup each
    phase_sky[0] = 0;     phase_height[0] = 240;
    phase_sky[1] = 1023;  phase_height[1] = 1024;
    phase_sky[2] = 80;    phase_height[2] = 240;
    phase_sky[3] = 300;   phase_height[3] = 600;
    phase_sky[4] = 1;     phase_height[4] = 1;
    phase_sky[5] = SKY_W'($urandom_range(1023));
    phase_height[5] = FH_W'($urandom_range(1, 1024));
    phase_sky[6] = SKY_W'($urandom_range(1023));
    phase_height[6] = FH_W'($urandom_range(2047));
    phase_sky[7] = 600;   phase_height[7] = 2047;

    for (int p = 0; p < PHASES; p++) begin
      wait_for_results();
      load_frame_setup(phase_sky[p], phase_height[p]);
      cut = (height_cfg / 3) * 2;
      // phase 3 runs with no idling on either side
      idle_on = (p != 3);
      // phase 2 opens with a long receiver hold-off so the pipe fills
      if (p == 2) hold_start = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) wait_for_results();
        kind = $urandom_range(9);
        case (kind)
          4, 5: begin
            // short segment around a random point
            x0 = $urandom_range(1008);
            y0 = $urandom_range(1008);
            sx = coord_t'(x0 + $urandom_range(15));
            ex = coord_t'(x0 + $urandom_range(15));
            sy = coord_t'(y0 + $urandom_range(15));
            ey = coord_t'(y0 + $urandom_range(15));
          end
          6, 7: begin
            // slope within one row of tan(15 deg)
            dx = $urandom_range(1, 1000);
            v = int'((longint'(TAN15_Q32) * dx) >> 32) + int'($urandom_range(2)) - 1;
            dy = (v < 0) ? 0 : v;
            x0 = $urandom_range(1023 - dx);
            y0 = $urandom_range(1023 - dy);
            if ($urandom_range(1)) begin
              sx = coord_t'(x0);
              ex = coord_t'(x0 + dx);
            end else begin
              sx = coord_t'(x0 + dx);
              ex = coord_t'(x0);
            end
            if ($urandom_range(1)) begin
              sy = coord_t'(y0);
              ey = coord_t'(y0 + dy);
            end else begin
              sy = coord_t'(y0 + dy);
              ey = coord_t'(y0);
            end
          end
          8: begin
            // horizontal, vertical or zero length
            sx = coord_t'($urandom);
            sy = coord_t'($urandom);
            ex = coord_t'($urandom);
            ey = coord_t'($urandom);
            case ($urandom_range(2))
              0: ey = sy;
              1: ex = sx;
              default: begin
                ex = sx;
                ey = sy;
              end
            endcase
          end
          9: begin
            // rows on either side of the sky row and the cut row
            sx = coord_t'($urandom);
            ex = coord_t'($urandom);
            v = ($urandom_range(1) ? int'(sky_cfg) : int'(cut)) + int'($urandom_range(2)) - 1;
            sy = coord_t'((v < 0) ? 0 : (v > 1023) ? 1023 : v);
            v = ($urandom_range(1) ? int'(sky_cfg) : int'(cut)) + int'($urandom_range(2)) - 1;
            ey = coord_t'((v < 0) ? 0 : (v > 1023) ? 1023 : v);
          end
          default: begin
            sx = coord_t'($urandom);
            sy = coord_t'($urandom);
            ex = coord_t'($urandom);
            ey = coord_t'($urandom);
          end
        endcase
        offer_segment(sx, sy, ex, ey, classify_segment(sx, sy, ex, ey));
      end
    end

    wait_for_results();
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("line_segment_classifier_test: clean");
    else
      $display("line_segment_classifier_test: errors");
    $finish;
  end

  // Watchdog
  initial begin
    #2400000;
    $display("line_segment_classifier_test: errors");
    $finish;
  end

endmodule

### line_segment_classifier.f
design/lsc_pkg.sv
design/lsc_geom.sv
design/lsc_isqrt.sv
design/lsc_weight.sv
design/line_segment_classifier.sv
test/line_segment_classifier_test.sv
